// ===== hw/rtl/hd44_pkg.sv =====
// Shared types and constants for the HD44780 expander sequencer.
`timescale 1ns / 1ps

package hd44_pkg;

    localparam logic [1:0] OP_TEXT = 2'd0;
    localparam logic [1:0] OP_CMD  = 2'd1;
    localparam logic [1:0] OP_INIT = 2'd2;

    localparam logic [1:0] CFG_ADDR      = 2'd0;
    localparam logic [1:0] CFG_BACKLIGHT = 2'd1;
    localparam logic [1:0] CFG_LINE_LEN  = 2'd2;

    localparam logic [6:0] RESET_ADDR     = 7'h27;
    localparam logic       RESET_BL       = 1'b1;
    localparam logic [5:0] RESET_LINE_LEN = 6'd16;

    localparam logic [7:0] CHAR_END   = 8'h00;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CMD_LINE2  = 8'hC0;

    localparam int NIB_MAX = 8;

    // power-up: three 0x3 nibbles, 0x2 nibble, then 0x0F and 0x01 as byte pairs
    localparam logic [NIB_MAX-1:0][3:0] INIT_NIBBLES =
        {4'h1, 4'h0, 4'hF, 4'h0, 4'h2, 4'h3, 4'h3, 4'h3};

    typedef struct packed {
        logic [NIB_MAX-1:0][3:0] nib;
        logic [NIB_MAX-1:0]      rs;
        logic [2:0]              last_idx;
    } desc_t;

endpackage

// ===== hw/rtl/hd44780_i2c_expander_sequencer_unit.sv =====
// Top level: config registers, front end, descriptor queue and back end.
// An input transfer is written to the descriptor queue; the back end registers each byte.
// Throughput: one expander byte per cycle while m_tready allows. A character is two nibbles
// (four on a wrap), a command two, init eight, three bytes per nibble; end-of-string has none.
// Front end accepts while the descriptor queue has room, independent of the back end.
// Reset (aresetn low, synchronous) clears column, queue and output; config returns to defaults.
`timescale 1ns / 1ps

module hd44780_i2c_expander_sequencer_unit
    import hd44_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[7:0]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // expander_byte[7:0], device_address[14:8], zero pad
    output logic        m_tlast
);

    logic [6:0] addr_reg;
    logic       bl_reg;
    logic [5:0] line_len_reg;

    logic  q_full;
    logic  q_push;
    desc_t q_desc;
    logic  q_pop;
    logic  q_valid;
    desc_t q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg     <= RESET_ADDR;
            bl_reg       <= RESET_BL;
            line_len_reg <= RESET_LINE_LEN;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ADDR:      addr_reg     <= cfg_wdata;
                CFG_BACKLIGHT: bl_reg       <= cfg_wdata[0];
                CFG_LINE_LEN:  line_len_reg <= cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    hd44_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .line_length (line_len_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_desc      (q_desc)
    );

    hd44_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (q_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (q_head)
    );

    hd44_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (q_valid),
        .head_desc        (q_head),
        .pop              (q_pop),
        .expander_address (addr_reg),
        .backlight_on     (bl_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast)
    );

endmodule

// ===== hw/rtl/hd44_front.sv =====
// Front end: classifies input items, tracks the column, builds nibble descriptors.
`timescale 1ns / 1ps

module hd44_front
    import hd44_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_code[7:0]
    input  logic [1:0] s_tuser,   // op[1:0]
    input  logic [5:0] line_length,
    input  logic       q_full,
    output logic       q_push,
    output desc_t      q_desc
);

    logic [5:0] column_reg;
    logic [5:0] column_next;
    logic       emits;
    logic       accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && emits;

    always_comb begin
        q_desc      = '0;
        emits       = 1'b0;
        column_next = column_reg;
        case (s_tuser)
            OP_TEXT: begin
                if (s_tdata == CHAR_END) begin
                    column_next = '0;
                end else if (s_tdata == CHAR_NL) begin
                    emits           = 1'b1;
                    q_desc.nib[0]   = CMD_LINE2[7:4];
                    q_desc.nib[1]   = CMD_LINE2[3:0];
                    q_desc.last_idx = 3'd1;
                    column_next     = '0;
                end else if (column_reg >= line_length) begin
                    emits           = 1'b1;
                    q_desc.nib[0]   = CMD_LINE2[7:4];
                    q_desc.nib[1]   = CMD_LINE2[3:0];
                    q_desc.nib[2]   = s_tdata[7:4];
                    q_desc.nib[3]   = s_tdata[3:0];
                    q_desc.rs[2]    = 1'b1;
                    q_desc.rs[3]    = 1'b1;
                    q_desc.last_idx = 3'd3;
                    column_next     = 6'd1;
                end else begin
                    emits           = 1'b1;
                    q_desc.nib[0]   = s_tdata[7:4];
                    q_desc.nib[1]   = s_tdata[3:0];
                    q_desc.rs[0]    = 1'b1;
                    q_desc.rs[1]    = 1'b1;
                    q_desc.last_idx = 3'd1;
                    column_next     = column_reg + 6'd1;
                end
            end
            OP_CMD: begin
                emits           = 1'b1;
                q_desc.nib[0]   = s_tdata[7:4];
                q_desc.nib[1]   = s_tdata[3:0];
                q_desc.last_idx = 3'd1;
            end
            OP_INIT: begin
                emits           = 1'b1;
                q_desc.nib      = INIT_NIBBLES;
                q_desc.last_idx = 3'(NIB_MAX - 1);
                column_next     = '0;
            end
            default: begin
                emits = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
        end else if (accept) begin
            column_reg <= column_next;
        end
    end

endmodule

// ===== hw/rtl/hd44_fifo.sv =====
// Small descriptor queue between front and back ends.
`timescale 1ns / 1ps

module hd44_fifo
    import hd44_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head_desc
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/hd44_back.sv =====
// Back end: expands each descriptor into enable-strobed expander bytes.
`timescale 1ns / 1ps

module hd44_back
    import hd44_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  desc_t       head_desc,
    output logic        pop,
    input  logic [6:0]  expander_address,
    input  logic        backlight_on,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // expander_byte[7:0], device_address[14:8], zero pad
    output logic        m_tlast
);

    desc_t      desc_reg;
    logic       busy_reg;
    logic [2:0] nib_idx_reg;
    logic [1:0] sub_reg;
    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic [6:0] m_addr_reg;
    logic       m_last_reg;

    desc_t      cur_desc;
    logic [2:0] cur_idx;
    logic [1:0] cur_sub;
    logic       fire;
    logic       is_last;
    logic [7:0] out_byte;

    assign cur_desc = busy_reg ? desc_reg : head_desc;
    assign cur_idx  = busy_reg ? nib_idx_reg : 3'd0;
    assign cur_sub  = busy_reg ? sub_reg : 2'd0;
    assign fire     = (busy_reg || head_valid) && (!m_valid_reg || m_tready);
    assign pop      = fire && !busy_reg;
    assign is_last  = (cur_sub == 2'd2) && (cur_idx == cur_desc.last_idx);
    // nibble, backlight, enable on middle phase, rw low, register select
    assign out_byte = {cur_desc.nib[cur_idx], backlight_on, (cur_sub == 2'd1), 1'b0,
                       cur_desc.rs[cur_idx]};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_addr_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            nib_idx_reg <= '0;
            sub_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
            busy_reg    <= !is_last;
            if (cur_sub == 2'd2) begin
                sub_reg     <= 2'd0;
                nib_idx_reg <= cur_idx + 3'd1;
            end else begin
                sub_reg     <= cur_sub + 2'd1;
                nib_idx_reg <= cur_idx;
            end
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            desc_reg   <= cur_desc;
            m_byte_reg <= out_byte;
            m_addr_reg <= expander_address;
            m_last_reg <= is_last;
        end
    end

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (nib_idx_reg <= desc_reg.last_idx))
        else $error("nibble index past end of descriptor");

    a_sub_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (sub_reg != 2'd3))
        else $error("strobe phase out of range");

    a_last_enable_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> !m_byte_reg[2])
        else $error("final byte of an item left enable high");

endmodule
